>>> hdl/vertex_component_to_float4_core_defines.svh
// assertion macros for the vertex component converter
`ifndef VERTEX_COMPONENT_TO_FLOAT4_CORE_DEFINES_SVH
`define VERTEX_COMPONENT_TO_FLOAT4_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define VCF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define VCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hdl/vcf4_pkg.sv
// shared types, codes and constants for the vertex component converter
package vcf4_pkg;
	localparam int unsigned LANES = 4;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned USED_W = 5;

	localparam logic [CODE_W-1:0] CODE_F1 = 8'd0;
	localparam logic [CODE_W-1:0] CODE_F2 = 8'd1;
	localparam logic [CODE_W-1:0] CODE_F3 = 8'd2;
	localparam logic [CODE_W-1:0] CODE_F4 = 8'd3;
	localparam logic [CODE_W-1:0] CODE_I1 = 8'd4;
	localparam logic [CODE_W-1:0] CODE_I2 = 8'd5;
	localparam logic [CODE_W-1:0] CODE_I4 = 8'd6;
	localparam logic [CODE_W-1:0] CODE_S2 = 8'd7;
	localparam logic [CODE_W-1:0] CODE_S4 = 8'd8;
	localparam logic [CODE_W-1:0] CODE_B4 = 8'd9;

	// per-lane control decoded from the format code
	typedef struct packed {
		logic       en;
		logic       pass;
	} lane_ctl_t;
endpackage

>>> hdl/vcf4_lane.sv
// one conversion lane: integer to single precision or float pass-through
module vcf4_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  vcf4_pkg::lane_ctl_t   ctl,
	input  logic [31:0]           src,
	output logic [31:0]           result
);
	import vcf4_pkg::*;

	logic        sign;
	logic [31:0] mag;
	logic [4:0]  msb;
	logic        nz;
	logic [31:0] norm;
	logic [24:0] keep;
	logic        rnd;
	logic [31:0] conv;

	lane_ctl_t   ctl_s1;
	logic [31:0] src_s1;
	logic        sign_s1;
	logic [31:0] norm_s1;
	logic [4:0]  msb_s1;
	logic        nz_s1;

	// stage 0: magnitude, leading one, normalize
	always_comb begin
		sign = src[31];
		mag  = sign ? (32'd0 - src) : src;
		msb  = 5'd0;
		nz   = |mag;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) begin
				msb = 5'(i);
			end
		end
		norm = mag << (5'd31 - msb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1  <= src;
			sign_s1 <= sign;
			norm_s1 <= norm;
			msb_s1  <= msb;
			nz_s1   <= nz;
		end
	end

	// stage 1: round to nearest even, pack, and pick zero, pass-through or the converted value
	always_comb begin
		rnd  = norm_s1[7] & ((|norm_s1[6:0]) | norm_s1[8]);
		keep = {1'b0, norm_s1[31:8]} + 25'(rnd);
		conv = {sign_s1, 31'd0} + {1'b0, 3'd0, msb_s1, 23'd0}
			+ {1'b0, 8'd127, 23'd0} + {7'd0, keep} - 32'h0080_0000;
		if (!ctl_s1.en) begin
			result = '0;
		end else if (ctl_s1.pass) begin
			result = src_s1;
		end else if (!nz_s1) begin
			result = '0;
		end else begin
			result = conv;
		end
	end
endmodule

>>> hdl/vertex_component_to_float4_core.sv
// top level: format decode, four conversion lanes and output register
// an accepted beat is registered in the lane stage, then in the output register
// throughput: one beat per cycle while the output is not stalled; the output register and lane stage stall together
// the lane stage register splits the leading-one search from the rounding adder
// reset clears the valid flags and the lane controls; payload registers are not reset
module vertex_component_to_float4_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [vcf4_pkg::CODE_W-1:0]  command,
	input  logic [31:0]                  word0,
	input  logic [31:0]                  word1,
	input  logic [31:0]                  word2,
	input  logic [31:0]                  word3,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  x_bits,
	output logic [31:0]                  y_bits,
	output logic [31:0]                  z_bits,
	output logic [31:0]                  w_bits,
	output logic [vcf4_pkg::USED_W-1:0]  bytes_used
);
	import vcf4_pkg::*;
	`include "vertex_component_to_float4_core_defines.svh"

	// pipeline moves as a whole when the output side is free
	logic                 adv;
	logic                 v_s1;
	logic [USED_W-1:0]    used_s1;
	lane_ctl_t            ctl [LANES];
	logic [31:0]          src [LANES];
	logic [31:0]          res [LANES];
	logic [USED_W-1:0]    used;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// decode the format code into per-lane enable, pass and source select
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ctl[i] = '0;
		end
		src[0] = word0;
		src[1] = word1;
		src[2] = word2;
		src[3] = word3;
		used   = '0;
		case (command)
			CODE_F1, CODE_F2, CODE_F3, CODE_F4: begin
				for (int i = 0; i < LANES; i++) begin
					ctl[i].en   = (i <= int'(command[1:0]));
					ctl[i].pass = 1'b1;
				end
				// four bytes per float, up to sixteen
				used = {1'b0, command[1:0], 2'b00} + 5'd4;
			end
			CODE_I1: begin
				ctl[0].en = 1'b1;
				used = 5'd4;
			end
			CODE_I2: begin
				ctl[0].en = 1'b1;
				ctl[1].en = 1'b1;
				used = 5'd8;
			end
			CODE_I4: begin
				for (int i = 0; i < LANES; i++) ctl[i].en = 1'b1;
				used = 5'd16;
			end
			CODE_S2, CODE_S4: begin
				// sign-extended half words, low half first
				src[0] = {{16{word0[15]}}, word0[15:0]};
				src[1] = {{16{word0[31]}}, word0[31:16]};
				src[2] = {{16{word1[15]}}, word1[15:0]};
				src[3] = {{16{word1[31]}}, word1[31:16]};
				ctl[0].en = 1'b1;
				ctl[1].en = 1'b1;
				ctl[2].en = (command == CODE_S4);
				ctl[3].en = (command == CODE_S4);
				used = (command == CODE_S4) ? 5'd8 : 5'd4;
			end
			CODE_B4: begin
				src[0] = {24'd0, word0[7:0]};
				src[1] = {24'd0, word0[15:8]};
				src[2] = {24'd0, word0[23:16]};
				src[3] = {24'd0, word0[31:24]};
				for (int i = 0; i < LANES; i++) ctl[i].en = 1'b1;
				used = 5'd4;
			end
			default: begin
				used = '0;
			end
		endcase
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		vcf4_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl    (ctl[g]),
			.src    (src[g]),
			.result (res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// merge stage: lane results and byte count into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			used_s1    <= used;
			x_bits     <= res[0];
			y_bits     <= res[1];
			z_bits     <= res[2];
			w_bits     <= res[3];
			bytes_used <= used_s1;
		end
	end

	`VCF_ASSERT_IMP(a_stall_hold, out_valid && out_stall, in_stall, "input not stalled")
	`VCF_ASSERT_NEXT(a_fill, v_s1 && adv, out_valid, "beat lost in pipeline")
	`VCF_ASSERT_IMP(a_used_max, out_valid, bytes_used <= 5'd16, "byte count out of range")
endmodule

>>> tb/sv/vertex_component_to_float4_core_tb.sv
// self-checking testbench for the vertex component to float4 converter
`timescale 1ns / 1ps
module vertex_component_to_float4_core_tb;
	import vcf4_pkg::*;

	localparam int RANDOM_BEATS = 1900;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [31:0] w0, w1, w2, w3;
	} attr_beat_t;

	typedef struct packed {
		logic [31:0] x, y, z, w;
		logic [USED_W-1:0] used;
	} float4_t;

	// directed row: known result given only where it is obvious
	typedef struct packed {
		attr_beat_t beat;
		logic known;
		float4_t res;
	} attr_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CODE_W-1:0] command = '0;
	logic [31:0] word0 = '0, word1 = '0, word2 = '0, word3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] x_bits, y_bits, z_bits, w_bits;
	logic [USED_W-1:0] bytes_used;

	float4_t lanes_pending[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int beats_sent = 0;
	int beats_seen = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;

	vertex_component_to_float4_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .word0(word0), .word1(word1), .word2(word2),
		.word3(word3), .out_valid(out_valid), .out_stall(out_stall),
		.x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits), .w_bits(w_bits),
		.bytes_used(bytes_used)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// signed 32-bit integer to single precision, round to nearest even
	function automatic logic [31:0] int_to_single(logic [31:0] v);
		logic sgn;
		logic [31:0] mag, rem, half, keep;
		int msb, sh;
		sgn = v[31];
		mag = sgn ? -v : v;
		msb = 0;
		if (mag == 0)
			return 32'd0;
		for (int i = 0; i < 32; i++)
			if (mag[i])
				msb = i;
		if (msb <= 23) begin
			keep = mag << (23 - msb);
		end else begin
			sh = msb - 23;
			rem = mag & ((32'd1 << sh) - 1);
			half = 32'd1 << (sh - 1);
			keep = mag >> sh;
			if (rem > half || (rem == half && keep[0]))
				keep = keep + 1;
		end
		// a rounding carry into bit 24 lands in the exponent
		return {sgn, 31'd0} + ((msb + 127) << 23) + (keep - 32'h0080_0000);
	endfunction

	function automatic float4_t convert_attr(attr_beat_t b);
		float4_t r;
		logic [31:0] w[4];
		logic [31:0] l[4];
		w = '{b.w0, b.w1, b.w2, b.w3};
		l = '{default: 32'd0};
		r.used = '0;
		case (b.code)
			CODE_F1, CODE_F2, CODE_F3, CODE_F4: begin
				for (int i = 0; i <= int'(b.code); i++)
					l[i] = w[i];
				r.used = USED_W'(4 * (int'(b.code) + 1));
			end
			CODE_I1, CODE_I2, CODE_I4: begin
				for (int i = 0; i < (b.code == CODE_I1 ? 1 : b.code == CODE_I2 ? 2 : 4); i++)
					l[i] = int_to_single(w[i]);
				r.used = USED_W'(b.code == CODE_I1 ? 4 : b.code == CODE_I2 ? 8 : 16);
			end
			CODE_S2, CODE_S4: begin
				for (int i = 0; i < (b.code == CODE_S2 ? 2 : 4); i++)
					l[i] = int_to_single({{16{w[i/2][16*(i%2)+15]}}, w[i/2][16*(i%2) +: 16]});
				r.used = USED_W'(b.code == CODE_S2 ? 4 : 8);
			end
			CODE_B4: begin
				for (int i = 0; i < 4; i++)
					l[i] = int_to_single({24'd0, b.w0[8*i +: 8]});
				r.used = 5'd4;
			end
			default: ;
		endcase
		r.x = l[0]; r.y = l[1]; r.z = l[2]; r.w = l[3];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch beat %0d %s: got %h want %h", beats_seen, what, got, want);
		mismatches++;
	endtask

	function automatic attr_beat_t random_beat();
		attr_beat_t b;
		int pick;
		pick = $urandom_range(0, 19);
		b.code = pick < 18 ? CODE_W'(pick % 10) : CODE_W'($urandom_range(10, 255));
		b.w0 = $urandom; b.w1 = $urandom; b.w2 = $urandom; b.w3 = $urandom;
		// small magnitudes and rounding-boundary values now and then
		if ($urandom_range(0, 3) == 0) begin
			b.w0 = $urandom_range(0, 300) - 150;
			b.w1 = 32'h0100_0000 + $urandom_range(0, 7);
			b.w2 = -(32'h0100_0000 + $urandom_range(0, 7));
			b.w3 = {$urandom_range(0, 1) ? 8'h80 : 8'h7f, 24'($urandom)};
		end
		return b;
	endfunction

	// send one beat after a random gap, hold payload until accepted
	task automatic send_beat(attr_beat_t b);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= b.code;
		word0 <= b.w0; word1 <= b.w1; word2 <= b.w2; word3 <= b.w3;
		lanes_pending.push_back(convert_attr(b));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// stimulus
	initial begin
		attr_row_t rows[$];
		attr_row_t r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// unknown codes give zeros and consume nothing
		r = '0; r.beat = '{8'd10, '1, '1, '1, '1}; r.known = 1; rows.push_back(r);
		r = '0; r.beat = '{8'd255, '1, '1, '1, '1}; r.known = 1; rows.push_back(r);
		// float pass-through: nan, infinity, denormal, negative zero
		r = '0; r.beat = '{CODE_F4, 32'h7fc0_1234, 32'hff80_0000, 32'h0000_0001, 32'h8000_0000};
		r.known = 1; r.res = '{32'h7fc0_1234, 32'hff80_0000, 32'h0000_0001, 32'h8000_0000, 5'd16};
		rows.push_back(r);
		r = '0; r.beat = '{CODE_F1, 32'h3f80_0000, '1, '1, '1};
		r.known = 1; r.res = '{32'h3f80_0000, 0, 0, 0, 5'd4}; rows.push_back(r);
		r = '0; r.beat = '{CODE_F2, '1, '0, '1, '1}; rows.push_back(r);
		r = '0; r.beat = '{CODE_F3, '0, '1, '1, '1}; rows.push_back(r);
		// integer extremes and zero, then half-word and byte formats
		r = '0; r.beat = '{CODE_I1, 32'd0, '1, '1, '1};
		r.known = 1; r.res = '{0, 0, 0, 0, 5'd4}; rows.push_back(r);
		r = '0; r.beat = '{CODE_I4, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1};
		r.known = 1; r.res = '{32'hcf00_0000, 32'h4f00_0000, 32'hbf80_0000, 32'h3f80_0000, 5'd16};
		rows.push_back(r);
		r = '0; r.beat = '{CODE_I2, 32'h0100_0001, 32'h0100_0003, 0, 0}; rows.push_back(r);
		r = '0; r.beat = '{CODE_S2, 32'h8000_7fff, '1, '1, '1}; rows.push_back(r);
		r = '0; r.beat = '{CODE_S4, 32'hffff_0000, 32'h0001_8001, '1, '1}; rows.push_back(r);
		r = '0; r.beat = '{CODE_B4, 32'hff00_80_01, '1, '1, '1};
		r.known = 1; r.res = '{32'h3f80_0000, 32'h4300_0000, 0, 32'h437f_0000, 5'd4};
		rows.push_back(r);
		foreach (rows[i]) begin
			if (rows[i].known && convert_attr(rows[i].beat) != rows[i].res)
				report_mismatch("directed table", 0, i);
			send_beat(rows[i].beat);
		end
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == 600)
				hold_off = 1'b1;
			send_beat(random_beat());
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stalls and one long hold-off to back the block up
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
			end
			wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// result check on every accepted output beat
	always @(posedge clk) begin
		float4_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (lanes_pending.size() == 0) begin
				report_mismatch("unexpected beat", x_bits, 0);
			end else begin
				want = lanes_pending.pop_front();
				if (x_bits !== want.x) report_mismatch("x", x_bits, want.x);
				if (y_bits !== want.y) report_mismatch("y", y_bits, want.y);
				if (z_bits !== want.z) report_mismatch("z", z_bits, want.z);
				if (w_bits !== want.w) report_mismatch("w", w_bits, want.w);
				if (bytes_used !== want.used)
					report_mismatch("used", 32'(bytes_used), 32'(want.used));
			end
			beats_seen++;
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress, %0d beats outstanding", lanes_pending.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (lanes_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d beats, checked %0d results over all formats and unknown codes",
			beats_sent, beats_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/vcf4_pkg.sv
hdl/vcf4_lane.sv
hdl/vertex_component_to_float4_core.sv
tb/sv/vertex_component_to_float4_core_tb.sv
